// ----- design/per_class_greedy_box_suppression_assert.svh -----
// assertion macros shared by the suppression block
// expects a clock named clk and a reset named rst in the using module
`ifndef PER_CLASS_GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define PER_CLASS_GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// condition in the same cycle implies the consequence
`define PCGBS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcgbs assertion failed");

// condition implies the consequence in the following cycle
`define PCGBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcgbs assertion failed");

`endif

// ----- design/pcgbs_pkg.sv -----
// types and constants of the per-class greedy box suppression block
// no dependencies
package pcgbs_pkg;

  localparam int MAX_KEPT = 256;
  localparam int IDX_W    = $clog2(MAX_KEPT);
  localparam int CNT_W    = IDX_W + 1;
  localparam int COORD_W  = 19;
  localparam int SIDE_W   = 18;
  localparam int AREA_W   = 2 * SIDE_W;

  // result verdict codes
  localparam logic [1:0] VERDICT_KEPT       = 2'd0;
  localparam logic [1:0] VERDICT_SUPPRESSED = 2'd1;
  localparam logic [1:0] VERDICT_DROPPED    = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_OVERLAP_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_KEEP_LIMIT        = 8'd1;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  class_label;
    logic        final_candidate;
  } cand_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] kept_position;
    logic [8:0] kept_total;
    logic       frame_done;
  } res_t;

  // corner box at twice the input scale, with its class
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [7:0]                cls;
  } box_t;

  // control between the sequencer and one ring cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ----- design/pcgbs_cell.sv -----
// one kept-box cell of the rotating ring
// depends on pcgbs_pkg
module pcgbs_cell (
  input  logic              clk,
  input  pcgbs_pkg::cell_ctl_t ctl,
  input  pcgbs_pkg::box_t   from_next,
  input  pcgbs_pkg::box_t   load_box,
  output pcgbs_pkg::box_t   box
);
  import pcgbs_pkg::*;

  box_t held;

  // take the neighbor's box on a shift, a new kept box on a load
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= load_box;
    end else if (ctl.shift) begin
      held <= from_next;
    end
  end

  assign box = held;
endmodule

// ----- design/pcgbs_overlap.sv -----
// pipelined overlap test of the candidate against the box at the ring head
// depends on pcgbs_pkg; head box to hit runs through the side, area, union, scaling and compare registers
module pcgbs_overlap (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  pcgbs_pkg::box_t             head,
  input  pcgbs_pkg::box_t             cand,
  input  logic [pcgbs_pkg::AREA_W-1:0] cand_area,
  input  logic [15:0]                 threshold,
  output logic                        hit
);
  import pcgbs_pkg::*;

  logic signed [COORD_W-1:0] rmin, lmax, bmin, tmax;
  logic signed [COORD_W:0]   iw, ih, wk, hk;

  logic              v1, v2, v3, v4;
  logic [SIDE_W-1:0] iw1, ih1, wk1, hk1;
  logic [AREA_W-1:0] inter2, areak2, inter3;
  logic [AREA_W:0]   uni3;
  logic [AREA_W:0]   uni_sum;
  logic [AREA_W+16:0] prod4;
  logic [AREA_W+15:0] lhs4;

  // intersection sides and kept box sides
  always_comb begin
    rmin = (head.right  < cand.right)  ? head.right  : cand.right;
    lmax = (head.left   > cand.left)   ? head.left   : cand.left;
    bmin = (head.bottom < cand.bottom) ? head.bottom : cand.bottom;
    tmax = (head.top    > cand.top)    ? head.top    : cand.top;
    iw = {rmin[COORD_W-1], rmin} - {lmax[COORD_W-1], lmax};
    ih = {bmin[COORD_W-1], bmin} - {tmax[COORD_W-1], tmax};
    wk = {head.right[COORD_W-1], head.right} - {head.left[COORD_W-1], head.left};
    hk = {head.bottom[COORD_W-1], head.bottom} - {head.top[COORD_W-1], head.top};
  end

  assign uni_sum = {1'b0, areak2} + {1'b0, cand_area} - {1'b0, inter2};

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v1  <= en && !iw[COORD_W] && !ih[COORD_W];
      v2  <= v1;
      v3  <= v2;
      v4  <= v3 && (uni3 != '0);
      hit <= v4 && ({1'b0, lhs4} > prod4);
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    iw1    <= iw[SIDE_W-1:0];
    ih1    <= ih[SIDE_W-1:0];
    wk1    <= wk[SIDE_W-1:0];
    hk1    <= hk[SIDE_W-1:0];
    inter2 <= iw1 * ih1;
    areak2 <= wk1 * hk1;
    inter3 <= inter2;
    uni3   <= uni_sum;
    lhs4   <= {inter3, 16'd0};
    prod4  <= threshold * uni3;
  end
endmodule

// ----- design/per_class_greedy_box_suppression.sv -----
// per-class greedy box suppression: one item at a time against a ring of kept boxes
// A ring of MAX_KEPT cells rotates once past a shared five-stage overlap unit.
// A new item is accepted only in idle, once the previous one has passed the whole ring
// rotation, the overlap drain and the issue of its result.
// Synchronous reset clears the kept count, registers to their reset values,
// the sequencer and the output valid; the ring contents are not cleared.
module per_class_greedy_box_suppression (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcgbs_pkg::cand_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pcgbs_pkg::res_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import pcgbs_pkg::*;
  `include "per_class_greedy_box_suppression_assert.svh"

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;
  localparam logic [2:0] DRAIN_LAST = 3'd4;

  logic [1:0]       state;
  logic [IDX_W-1:0] scan_idx;
  logic [2:0]       drain_cnt;
  logic [CNT_W-1:0] kept_count;
  logic [15:0]      overlap_threshold;
  logic [8:0]       keep_limit;
  logic             suppressed;
  box_t             cand;
  logic             cand_last;
  logic [AREA_W-1:0] cand_area;
  logic             hit;
  logic             head_en;
  logic             keep_it;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] count_new;
  logic             out_free;
  box_t             ring [MAX_KEPT];

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_threshold <= 16'd29491;
      keep_limit        <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OVERLAP_THRESHOLD) begin
        overlap_threshold <= cfg_data;
      end else if (cfg_index == REG_KEEP_LIMIT) begin
        keep_limit <= cfg_data[8:0];
      end
    end
  end

  // candidate capture: corners at twice the scale and area
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cand.left   <= COORD_W'({2'b0, in_data.center_x, 1'b0})
                     - COORD_W'({3'b0, in_data.box_width});
      cand.right  <= COORD_W'({2'b0, in_data.center_x, 1'b0})
                     + COORD_W'({3'b0, in_data.box_width});
      cand.top    <= COORD_W'({2'b0, in_data.center_y, 1'b0})
                     - COORD_W'({3'b0, in_data.box_height});
      cand.bottom <= COORD_W'({2'b0, in_data.center_y, 1'b0})
                     + COORD_W'({3'b0, in_data.box_height});
      cand.cls    <= in_data.class_label;
      cand_last   <= in_data.final_candidate;
      cand_area   <= {1'b0, in_data.box_width, 1'b0} * {1'b0, in_data.box_height, 1'b0};
    end
  end

  // kept-box ring, head at cell 0
  assign head_en = (state == ST_SCAN) && ({1'b0, scan_idx} < kept_count)
                   && (ring[0].cls == cand.cls);

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_ring
    cell_ctl_t ctl;
    assign ctl.shift = (state == ST_SCAN);
    assign ctl.load  = (state == ST_FINISH) && out_free && keep_it
                       && (kept_count[IDX_W-1:0] == IDX_W'(i));
    pcgbs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_next (ring[(i + 1) % MAX_KEPT]),
      .load_box  (cand),
      .box       (ring[i])
    );
  end

  pcgbs_overlap u_overlap (
    .clk       (clk),
    .rst       (rst),
    .en        (head_en),
    .head      (ring[0]),
    .cand      (cand),
    .cand_area (cand_area),
    .threshold (overlap_threshold),
    .hit       (hit)
  );

  // verdict
  always_comb begin
    limit     = (keep_limit > 9'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : CNT_W'(keep_limit);
    keep_it   = !suppressed && (kept_count < limit);
    count_new = keep_it ? kept_count + CNT_W'(1) : kept_count;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      drain_cnt  <= '0;
      kept_count <= '0;
      suppressed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // the finish state sets the valid itself when the slot frees
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state      <= ST_SCAN;
            scan_idx   <= '0;
            suppressed <= 1'b0;
          end
        end
        ST_SCAN: begin
          suppressed <= suppressed | hit;
          scan_idx   <= scan_idx + IDX_W'(1);
          if (scan_idx == IDX_W'(MAX_KEPT - 1)) begin
            state     <= ST_DRAIN;
            drain_cnt <= '0;
          end
        end
        ST_DRAIN: begin
          suppressed <= suppressed | hit;
          drain_cnt  <= drain_cnt + 3'd1;
          if (drain_cnt == DRAIN_LAST) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            kept_count <= cand_last ? '0 : count_new;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_data.verdict       <= suppressed ? VERDICT_SUPPRESSED
                                : (keep_it ? VERDICT_KEPT : VERDICT_DROPPED);
      out_data.kept_position <= keep_it ? 8'(kept_count) : 8'd0;
      out_data.kept_total    <= 9'(count_new);
      out_data.frame_done    <= cand_last;
    end
  end

  `PCGBS_ASSERT_SAME(a_count_bound, 1'b1, kept_count <= CNT_W'(MAX_KEPT))
  `PCGBS_ASSERT_NEXT(a_accept_scan, in_valid && in_ready,
                     state == ST_SCAN && scan_idx == '0)
  `PCGBS_ASSERT_NEXT(a_scan_end, state == ST_SCAN && scan_idx == IDX_W'(MAX_KEPT - 1),
                     state == ST_DRAIN)
endmodule
